>>> src/cpqf_pkg.sv
// Shared constants, codes and types for the CAR prior quadratic-form block.
// Used by car_prior_quadratic_form; depends on nothing else.
package cpqf_pkg;

  // Store geometry
  localparam int MAX_NODES = 1024;
  localparam int MAX_DIMS  = 8;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int DIM_W     = $clog2(MAX_DIMS);
  localparam int DCNT_W    = $clog2(MAX_DIMS + 1);

  // Port field widths
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 16;
  localparam int NCNT_W    = 8;
  localparam int REG_W     = 16;
  localparam int DIMS_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int TERM_W    = 64;

  // Datapath widths
  localparam int MA_W   = 17;  // multiplier operand A, signed
  localparam int MB_W   = 35;  // multiplier operand B, signed
  localparam int MP_W   = MA_W + MB_W;
  localparam int T_W    = 35;  // inner row sum, S*phi_c, 32 fraction bits
  localparam int Q_W    = 54;  // full quadratic form, 48 fraction bits
  localparam int V_W    = 47;  // quadratic form at 40 fraction bits, negated for pairs
  localparam int P_W    = 82;  // scaled term before the final shift
  localparam int PART_W = 16;  // slice of V fed to the multiplier per step

  localparam int Q_DROP     = 8;      // 48 -> 40 fraction bits
  localparam int SH_NODE    = 15;     // node coefficient is Q.15
  localparam int SH_PAIR    = 23;     // rho*w is Q.23
  localparam int COEF_ONE   = 32768;  // 1.0 in Q1.15

  // Scale sequence: one coefficient per rho, then V*m in slices per rho
  localparam int NUM_RHOS    = 2;
  localparam int NUM_PARTS   = 3;
  localparam int SCALE_STEPS = NUM_RHOS + NUM_RHOS * NUM_PARTS;
  localparam int STEP_W      = $clog2(SCALE_STEPS);
  localparam int PART_IDX_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_MAT = 3'd0,
    CMD_LOAD_PHI = 3'd1,
    CMD_NODE     = 3'd2,
    CMD_PAIR     = 3'd3,
    CMD_FINISH   = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RHO_NOW  = 2'd0,
    CFG_RHO_NEXT = 2'd1,
    CFG_WEIGHT   = 2'd2,
    CFG_DIMS     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INNER,
    ST_WAIT,
    ST_OUTER,
    ST_SCALE,
    ST_DRAIN,
    ST_EMIT_NOW,
    ST_EMIT_NEXT
  } state_t;

  // What the shared multiplier does with the operation in flight
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_INNER,   // S[a][b] * phi_c[b] into the row sum
    MOP_OUTER,   // phi_r[a] * row sum into the quadratic form
    MOP_COEF,    // rho * n or rho * w into a coefficient
    MOP_PART     // slice of V * coefficient into the scaled term
  } mop_t;

  typedef struct packed {
    mop_t                  op;
    logic                  first;
    logic                  is_next;
    logic [PART_IDX_W-1:0] part;
  } mul_tag_t;

  localparam mul_tag_t TAG_IDLE = '{op: MOP_NONE, first: 1'b0, is_next: 1'b0, part: '0};

endpackage

>>> src/car_prior_quadratic_form.sv
// CAR prior quadratic form for a current and a proposed rho.
// Loads take effect in the accept cycle. A node or pair item keeps the block busy
// (in_stall high) until its term is committed into its sum, so no new item is taken
// before then; one shared 17x35 multiplier does every product. A finish item puts its
// two results, current rho first, into the output register in turn as it is free.
// Reset: sums cleared, registers to defaults; the stores are not cleared.
// Depends on cpqf_pkg.
module car_prior_quadratic_form (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cpqf_pkg::CMD_W-1:0]          in_cmd,
  input  logic [cpqf_pkg::IDX_W-1:0]          in_first_index,
  input  logic [cpqf_pkg::IDX_W-1:0]          in_second_index,
  input  logic signed [cpqf_pkg::VAL_W-1:0]   in_entry_value,
  input  logic [cpqf_pkg::NCNT_W-1:0]         in_neighbour_count,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cpqf_pkg::TERM_W-1:0]  out_term_value,
  output logic                                out_is_proposal,
  output logic                                out_last,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpqf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpqf_pkg::REG_W-1:0]          cfg_data
);

  localparam int DIM_W   = cpqf_pkg::DIM_W;
  localparam int NODE_W  = cpqf_pkg::NODE_W;
  localparam int DCNT_W  = cpqf_pkg::DCNT_W;
  localparam int VAL_W   = cpqf_pkg::VAL_W;
  localparam int REG_W   = cpqf_pkg::REG_W;
  localparam int MA_W    = cpqf_pkg::MA_W;
  localparam int MB_W    = cpqf_pkg::MB_W;
  localparam int MP_W    = cpqf_pkg::MP_W;
  localparam int T_W     = cpqf_pkg::T_W;
  localparam int Q_W     = cpqf_pkg::Q_W;
  localparam int V_W     = cpqf_pkg::V_W;
  localparam int P_W     = cpqf_pkg::P_W;
  localparam int PART_W  = cpqf_pkg::PART_W;
  localparam int TERM_W  = cpqf_pkg::TERM_W;
  localparam int STEP_W  = cpqf_pkg::STEP_W;
  localparam int PIDX_W  = cpqf_pkg::PART_IDX_W;

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0]              rho_now_r, rho_next_r, weight_r;
  logic [cpqf_pkg::DIMS_W-1:0]   dims_r;
  logic [DCNT_W-1:0]             dims_eff, dims_m1;
  logic [DIM_W-1:0]              dlast;

  cpqf_pkg::state_t              state_r, state_nxt;
  logic [DIM_W-1:0]              a_r, a_nxt, b_r, b_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  cpqf_pkg::mul_tag_t            issue, tag1_r, tag2_r;

  cpqf_pkg::cmd_t                cmd;
  logic                          in_acc, term_go, fin_go, node_ok, pair_ok;
  logic                          mat_we, phi_we;
  logic [2*DIM_W-1:0]            mat_waddr;
  logic [NODE_W+DIM_W-1:0]       phi_waddr;

  logic [NODE_W-1:0]             r_r, c_r;
  logic                          pair_r;
  logic [cpqf_pkg::NCNT_W-1:0]   n_r;

  logic signed [VAL_W-1:0]       mat_mem [cpqf_pkg::MAX_DIMS*cpqf_pkg::MAX_DIMS];
  logic signed [VAL_W-1:0]       phi_mem [cpqf_pkg::MAX_NODES*cpqf_pkg::MAX_DIMS];
  logic signed [VAL_W-1:0]       mat_rd_r, phic_rd_r, phir_rd_r;

  logic signed [MA_W-1:0]        mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [MP_W-1:0]        prod_r;

  logic signed [T_W-1:0]         t_acc_r, t_base;
  logic signed [Q_W-1:0]         q_acc_r, q_base;
  logic signed [V_W-1:0]         q_sh, v_r;
  logic signed [MB_W-1:0]        m_now_r, m_next_r, coef_val;
  logic [REG_W-1:0]              rho_c2;
  logic signed [P_W-1:0]         p_acc_r, p_base, p_add, p_sh;

  logic                          commit_r, commit_next_r;
  logic signed [TERM_W-1:0]      term, sum_now_r, sum_next_r, sum_sel, sat_val;
  logic signed [TERM_W:0]        tot;

  logic                          out_valid_r, out_free, out_load, out_second;
  logic signed [TERM_W-1:0]      out_term_r;
  logic                          out_prop_r, out_last_r;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_now_r  <= '0;
      rho_next_r <= '0;
      weight_r   <= REG_W'(256);
      dims_r     <= cpqf_pkg::DIMS_W'(cpqf_pkg::MAX_DIMS);
    end else if (cfg_valid && cfg_ready) begin
      case (cpqf_pkg::cfg_reg_t'(cfg_index))
        cpqf_pkg::CFG_RHO_NOW:  rho_now_r  <= cfg_data;
        cpqf_pkg::CFG_RHO_NEXT: rho_next_r <= cfg_data;
        cpqf_pkg::CFG_WEIGHT:   weight_r   <= cfg_data;
        cpqf_pkg::CFG_DIMS:     dims_r     <= cfg_data[cpqf_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the store size as the store size
  always_comb begin
    if (dims_r == '0) begin
      dims_eff = DCNT_W'(1);
    end else if (32'(dims_r) > cpqf_pkg::MAX_DIMS) begin
      dims_eff = DCNT_W'(cpqf_pkg::MAX_DIMS);
    end else begin
      dims_eff = DCNT_W'(dims_r);
    end
  end
  assign dims_m1 = dims_eff - DCNT_W'(1);
  assign dlast   = dims_m1[DIM_W-1:0];

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != cpqf_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cmd      = cpqf_pkg::cmd_t'(in_cmd);

  assign node_ok = (32'(in_first_index) < cpqf_pkg::MAX_NODES);
  assign pair_ok = node_ok && (32'(in_second_index) < cpqf_pkg::MAX_NODES);

  assign mat_we = in_acc && (cmd == cpqf_pkg::CMD_LOAD_MAT)
                  && (32'(in_first_index) < cpqf_pkg::MAX_DIMS)
                  && (32'(in_second_index) < cpqf_pkg::MAX_DIMS);
  assign phi_we = in_acc && (cmd == cpqf_pkg::CMD_LOAD_PHI) && node_ok
                  && (32'(in_second_index) < cpqf_pkg::MAX_DIMS);
  assign mat_waddr = {in_first_index[DIM_W-1:0], in_second_index[DIM_W-1:0]};
  assign phi_waddr = {in_first_index[NODE_W-1:0], in_second_index[DIM_W-1:0]};

  assign term_go = in_acc && (((cmd == cpqf_pkg::CMD_NODE) && node_ok)
                              || ((cmd == cpqf_pkg::CMD_PAIR) && pair_ok));
  assign fin_go  = in_acc && (cmd == cpqf_pkg::CMD_FINISH);

  // Latch the term item
  always_ff @(posedge clk) begin
    if (term_go) begin
      pair_r <= (cmd == cpqf_pkg::CMD_PAIR);
      r_r    <= in_first_index[NODE_W-1:0];
      c_r    <= (cmd == cpqf_pkg::CMD_PAIR) ? in_second_index[NODE_W-1:0]
                                            : in_first_index[NODE_W-1:0];
      n_r    <= in_neighbour_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Stores: one write port, registered reads
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= in_entry_value;
    end
    mat_rd_r <= mat_mem[{a_r, b_r}];
  end

  // phi: column read for the row sum, row read for the outer product
  always_ff @(posedge clk) begin
    if (phi_we) begin
      phi_mem[phi_waddr] <= in_entry_value;
    end
    phic_rd_r <= phi_mem[{c_r, b_r}];
    phir_rd_r <= phi_mem[{r_r, a_r}];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpqf_pkg::ST_IDLE;
      a_r     <= '0;
      b_r     <= '0;
      step_r  <= '0;
      tag1_r  <= cpqf_pkg::TAG_IDLE;
      tag2_r  <= cpqf_pkg::TAG_IDLE;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      step_r  <= step_nxt;
      tag1_r  <= issue;
      tag2_r  <= tag1_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    step_nxt   = step_r;
    issue      = cpqf_pkg::TAG_IDLE;
    out_load   = 1'b0;
    out_second = 1'b0;
    case (state_r)
      cpqf_pkg::ST_IDLE: begin
        a_nxt    = '0;
        b_nxt    = '0;
        step_nxt = '0;
        if (term_go) begin
          state_nxt = cpqf_pkg::ST_INNER;
        end else if (fin_go) begin
          state_nxt = cpqf_pkg::ST_EMIT_NOW;
        end
      end
      // one S*phi_c product per cycle along row a
      cpqf_pkg::ST_INNER: begin
        issue.op    = cpqf_pkg::MOP_INNER;
        issue.first = (b_r == '0);
        if (b_r == dlast) begin
          b_nxt     = '0;
          state_nxt = cpqf_pkg::ST_WAIT;
        end else begin
          b_nxt = b_r + DIM_W'(1);
        end
      end
      // row sum still settling in the pipe
      cpqf_pkg::ST_WAIT: begin
        state_nxt = cpqf_pkg::ST_OUTER;
      end
      cpqf_pkg::ST_OUTER: begin
        issue.op    = cpqf_pkg::MOP_OUTER;
        issue.first = (a_r == '0);
        if (a_r == dlast) begin
          state_nxt = cpqf_pkg::ST_SCALE;
        end else begin
          a_nxt     = a_r + DIM_W'(1);
          state_nxt = cpqf_pkg::ST_INNER;
        end
      end
      // coefficients for both rhos, then V*m in slices, current rho first
      cpqf_pkg::ST_SCALE: begin
        if (step_r < STEP_W'(cpqf_pkg::NUM_RHOS)) begin
          issue.op      = cpqf_pkg::MOP_COEF;
          issue.is_next = step_r[0];
        end else if (step_r < STEP_W'(cpqf_pkg::NUM_RHOS + cpqf_pkg::NUM_PARTS)) begin
          issue.op    = cpqf_pkg::MOP_PART;
          issue.part  = PIDX_W'(step_r - STEP_W'(cpqf_pkg::NUM_RHOS));
          issue.first = (step_r == STEP_W'(cpqf_pkg::NUM_RHOS));
        end else begin
          issue.op      = cpqf_pkg::MOP_PART;
          issue.is_next = 1'b1;
          issue.part    = PIDX_W'(step_r - STEP_W'(cpqf_pkg::NUM_RHOS
                                                   + cpqf_pkg::NUM_PARTS));
          issue.first   = (step_r == STEP_W'(cpqf_pkg::NUM_RHOS + cpqf_pkg::NUM_PARTS));
        end
        if (step_r == STEP_W'(cpqf_pkg::SCALE_STEPS - 1)) begin
          state_nxt = cpqf_pkg::ST_DRAIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      // last commit lands in the cycle the pipe runs empty
      cpqf_pkg::ST_DRAIN: begin
        if ((tag1_r.op == cpqf_pkg::MOP_NONE) && (tag2_r.op == cpqf_pkg::MOP_NONE)) begin
          state_nxt = cpqf_pkg::ST_IDLE;
        end
      end
      cpqf_pkg::ST_EMIT_NOW: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = cpqf_pkg::ST_EMIT_NEXT;
        end
      end
      cpqf_pkg::ST_EMIT_NEXT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_second = 1'b1;
          state_nxt  = cpqf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpqf_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operand select, then registered product
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (tag1_r.op)
      cpqf_pkg::MOP_INNER: begin
        mul_a = MA_W'(mat_rd_r);
        mul_b = MB_W'(phic_rd_r);
      end
      cpqf_pkg::MOP_OUTER: begin
        mul_a = MA_W'(phir_rd_r);
        mul_b = MB_W'(t_acc_r);
      end
      cpqf_pkg::MOP_COEF: begin
        mul_a = {1'b0, (tag1_r.is_next ? rho_next_r : rho_now_r)};
        mul_b = pair_r ? MB_W'(weight_r) : MB_W'(n_r);
      end
      cpqf_pkg::MOP_PART: begin
        case (tag1_r.part)
          PIDX_W'(0): mul_a = {1'b0, v_r[PART_W-1:0]};
          PIDX_W'(1): mul_a = {1'b0, v_r[2*PART_W-1:PART_W]};
          default:    mul_a = MA_W'($signed(v_r[V_W-1:2*PART_W]));
        endcase
        mul_b = tag1_r.is_next ? m_next_r : m_now_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // Accumulators behind the product register
  // ---------------------------------------------------------------------------
  assign t_base = tag2_r.first ? T_W'(0) : t_acc_r;
  assign q_base = tag2_r.first ? Q_W'(0) : q_acc_r;
  assign p_base = tag2_r.first ? P_W'(0) : p_acc_r;
  assign p_add  = P_W'(prod_r) <<< (PART_W * int'(tag2_r.part));

  // node coefficient rho*n + 1 - rho; pair coefficient rho*w
  assign rho_c2   = tag2_r.is_next ? rho_next_r : rho_now_r;
  assign coef_val = pair_r ? MB_W'(prod_r)
                           : MB_W'(prod_r) + MB_W'(cpqf_pkg::COEF_ONE) - MB_W'(rho_c2);

  always_ff @(posedge clk) begin
    case (tag2_r.op)
      cpqf_pkg::MOP_INNER: t_acc_r <= t_base + T_W'(prod_r);
      cpqf_pkg::MOP_OUTER: q_acc_r <= q_base + Q_W'(prod_r);
      cpqf_pkg::MOP_COEF: begin
        if (tag2_r.is_next) begin
          m_next_r <= coef_val;
        end else begin
          m_now_r <= coef_val;
        end
      end
      cpqf_pkg::MOP_PART:  p_acc_r <= p_base + p_add;
      default: ;
    endcase
  end

  // Form rounded down to 40 fraction bits, negated for a pair term
  assign q_sh = V_W'(q_acc_r >>> cpqf_pkg::Q_DROP);
  always_ff @(posedge clk) begin
    v_r <= pair_r ? -q_sh : q_sh;
  end

  // ---------------------------------------------------------------------------
  // Commit the finished term into its sum, saturating
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_r <= 1'b0;
    end else begin
      commit_r <= (tag2_r.op == cpqf_pkg::MOP_PART)
                  && (tag2_r.part == PIDX_W'(cpqf_pkg::NUM_PARTS - 1));
    end
    commit_next_r <= tag2_r.is_next;
  end

  assign p_sh    = p_acc_r >>> (pair_r ? cpqf_pkg::SH_PAIR : cpqf_pkg::SH_NODE);
  assign term    = TERM_W'(p_sh);
  assign sum_sel = commit_next_r ? sum_next_r : sum_now_r;
  assign tot     = (TERM_W+1)'(sum_sel) + (TERM_W+1)'(term);

  always_comb begin
    if (tot[TERM_W] != tot[TERM_W-1]) begin
      sat_val = tot[TERM_W] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
    end else begin
      sat_val = TERM_W'(tot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_now_r  <= '0;
      sum_next_r <= '0;
    end else if (out_load && out_second) begin
      sum_now_r  <= '0;
      sum_next_r <= '0;
    end else if (commit_r) begin
      if (commit_next_r) begin
        sum_next_r <= sat_val;
      end else begin
        sum_now_r <= sat_val;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_term_r <= (out_second ? sum_next_r : sum_now_r) >>> 1;
      out_prop_r <= out_second;
      out_last_r <= out_second;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_term_value  = out_term_r;
  assign out_is_proposal = out_prop_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // nothing left in the multiplier pipe once the block takes items again
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpqf_pkg::ST_IDLE) |->
      (tag1_r.op == cpqf_pkg::MOP_NONE && tag2_r.op == cpqf_pkg::MOP_NONE && !commit_r))
    else $error("multiplier pipe busy while idle");

  // first finish result is the current rho one
  a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !out_second) |=> (out_valid && !out_is_proposal && !out_last))
    else $error("first finish result mislabeled");

  // second finish result closes the run and both sums start over
  a_second_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_second) |=>
      (out_valid && out_is_proposal && out_last && sum_now_r == '0 && sum_next_r == '0))
    else $error("finish did not clear sums or mislabeled result");

endmodule
